/* rtl/mkoc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkoc_pkg
// Shared constants and types for the multi-keyword occurrence counter.
// ----------------------------------------------------------------------------
package mkoc_pkg;

    localparam int KW_SLOTS          = 6;
    localparam int BYTE_W            = 8;
    localparam int MAX_LEN_LIMIT     = 8;
    localparam int KEYWORD_REG_W     = 64;
    localparam int LEN_FIELD_W       = 4;
    localparam int LENGTHS_W         = KW_SLOTS * LEN_FIELD_W;
    localparam int FIELD_COUNT_W     = 32;
    localparam int HITS_W            = KW_SLOTS;
    localparam int OUT_FIELDS_W      = KW_SLOTS * FIELD_COUNT_W + HITS_W;
    localparam int OUT_DATA_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int HITS_LSB          = KW_SLOTS * FIELD_COUNT_W;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = KEYWORD_REG_W;

    localparam int DEF_NUM_KEYWORDS    = 6;
    localparam int DEF_MAX_KEYWORD_LEN = 8;
    localparam int DEF_COUNT_WIDTH     = 32;

    localparam logic [BYTE_W-1:0]      NEWLINE_BYTE = 8'h0A;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTHS  = 3'd6;

    typedef struct packed {
        logic advance;
        logic clear;
    } cell_ctrl_t;

endpackage

/* rtl/mkoc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkoc_cell
// One shift-and position: holds one partial-match bit and passes it on.
// ----------------------------------------------------------------------------
module mkoc_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mkoc_pkg::cell_ctrl_t          ctrl,
    input  logic [mkoc_pkg::BYTE_W-1:0]   text_byte,
    input  logic [mkoc_pkg::BYTE_W-1:0]   kw_byte,
    input  logic                          in_use,
    input  logic                          carry_in,
    output logic                          d,
    output logic                          carry_out
);

    logic partial_reg;

    assign d         = carry_in & in_use & (kw_byte == text_byte);
    assign carry_out = partial_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            partial_reg <= ctrl.clear ? 1'b0 : d;
        end
    end

endmodule

/* rtl/mkoc_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkoc_lane
// One keyword: a chain of match cells plus its saturating match counter.
// ----------------------------------------------------------------------------
module mkoc_lane
#(
    parameter int MAX_KEYWORD_LEN = mkoc_pkg::DEF_MAX_KEYWORD_LEN,
    parameter int COUNT_WIDTH     = mkoc_pkg::DEF_COUNT_WIDTH
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          advance,
    input  logic [mkoc_pkg::BYTE_W-1:0]                   text_byte,
    input  logic [MAX_KEYWORD_LEN*mkoc_pkg::BYTE_W-1:0]   keyword,
    input  logic [mkoc_pkg::LEN_FIELD_W-1:0]              kw_len,
    output logic                                          hit,
    output logic [COUNT_WIDTH-1:0]                        count_next
);

    localparam int LW = mkoc_pkg::LEN_FIELD_W;

    logic                         len_ok;
    logic                         enable;
    logic [MAX_KEYWORD_LEN-1:0]   d;
    logic [MAX_KEYWORD_LEN-1:0]   last_sel;
    logic [MAX_KEYWORD_LEN:0]     carry;
    mkoc_pkg::cell_ctrl_t         ctrl;
    logic [COUNT_WIDTH-1:0]       count_reg;

    assign len_ok   = (kw_len != '0) && (kw_len <= LW'(MAX_KEYWORD_LEN));
    assign enable   = len_ok && (text_byte != mkoc_pkg::NEWLINE_BYTE);
    assign carry[0] = 1'b1;

    genvar i;
    generate
        for (i = 0; i < MAX_KEYWORD_LEN; i++)
        begin : g_cell
            assign last_sel[i] = (kw_len == LW'(i + 1));

            mkoc_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .text_byte (text_byte),
                .kw_byte   (keyword[i*mkoc_pkg::BYTE_W +: mkoc_pkg::BYTE_W]),
                .in_use    (LW'(i) < kw_len),
                .carry_in  (carry[i]),
                .d         (d[i]),
                .carry_out (carry[i+1])
            );
        end
    endgenerate

    assign hit          = enable && ((d & last_sel) != '0);
    assign ctrl.advance = advance;
    assign ctrl.clear   = !enable || hit;

    assign count_next = (hit && !(&count_reg)) ? count_reg + COUNT_WIDTH'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/multi_keyword_occurrence_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_keyword_occurrence_counter
// Counts non-overlapping keyword matches in a byte stream, one lane per keyword.
//
//   channel   dir  width  content
//   s_axis    in   8      text_byte
//   m_axis    out  200    count_0..count_5, match_hits
//   wr        in   64     keyword_0..keyword_5, keyword_lengths
//
// One byte per cycle while s_tready is high; every lane updates its cell chain
// and counter in the cycle the byte transfers, and the result sits in one
// output register; m_tvalid rises in the cycle after the input transfer.
// While the output register is full and m_tready is low, s_tready is low.
// Reset clears keywords, lengths, partial matches and counters.
// ----------------------------------------------------------------------------
module multi_keyword_occurrence_counter
#(
    parameter int NUM_KEYWORDS    = mkoc_pkg::DEF_NUM_KEYWORDS,
    parameter int MAX_KEYWORD_LEN = mkoc_pkg::DEF_MAX_KEYWORD_LEN,
    parameter int COUNT_WIDTH     = mkoc_pkg::DEF_COUNT_WIDTH
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mkoc_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] text_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] count_0 .. [191:160] count_5, [197:192] match_hits, rest zero
    output logic [mkoc_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                wr_en,
    input  logic [mkoc_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  logic [mkoc_pkg::CFG_DATA_W-1:0]     wr_data
);

    localparam int KW_W  = MAX_KEYWORD_LEN * mkoc_pkg::BYTE_W;
    localparam int CW    = mkoc_pkg::FIELD_COUNT_W;
    localparam int LW    = mkoc_pkg::LEN_FIELD_W;
    localparam int SLOTS = mkoc_pkg::KW_SLOTS;
    localparam int PAD_W = mkoc_pkg::OUT_DATA_W - mkoc_pkg::OUT_FIELDS_W;

    logic [KW_W-1:0]                   kw_reg [NUM_KEYWORDS];
    logic [mkoc_pkg::LENGTHS_W-1:0]    lengths_reg;
    logic [COUNT_WIDTH-1:0]            lane_count [NUM_KEYWORDS];
    logic [CW-1:0]                     slot_count [SLOTS];
    logic [SLOTS-1:0]                  slot_hit;
    logic                              accept;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [mkoc_pkg::OUT_DATA_W-1:0]   out_data_reg;
    logic [mkoc_pkg::OUT_DATA_W-1:0]   out_data_next;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lengths_reg <= '0;
        end
        else if (wr_en && (wr_index == mkoc_pkg::REG_LENGTHS))
        begin
            lengths_reg <= wr_data[mkoc_pkg::LENGTHS_W-1:0];
        end
    end

    genvar k;
    generate
        for (k = 0; k < SLOTS; k++)
        begin : g_slot
            if (k < NUM_KEYWORDS)
            begin : g_lane
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        kw_reg[k] <= '0;
                    end
                    else if (wr_en && (wr_index == mkoc_pkg::CFG_INDEX_W'(k)))
                    begin
                        kw_reg[k] <= wr_data[KW_W-1:0];
                    end
                end

                mkoc_lane
                #(
                    .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
                    .COUNT_WIDTH     (COUNT_WIDTH)
                )
                u_lane
                (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .advance    (accept),
                    .text_byte  (s_tdata),
                    .keyword    (kw_reg[k]),
                    .kw_len     (lengths_reg[k*LW +: LW]),
                    .hit        (slot_hit[k]),
                    .count_next (lane_count[k])
                );

                assign slot_count[k] = CW'(lane_count[k]);
            end
            else
            begin : g_unused
                assign slot_hit[k]   = 1'b0;
                assign slot_count[k] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        out_data_next = '0;
        for (int j = 0; j < SLOTS; j++)
        begin
            out_data_next[j*CW +: CW] = slot_count[j];
        end
        out_data_next[mkoc_pkg::HITS_LSB +: mkoc_pkg::HITS_W] = slot_hit;
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // a newline never completes a match
    a_newline_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tdata == mkoc_pkg::NEWLINE_BYTE))
        |=> (m_tdata[mkoc_pkg::HITS_LSB +: mkoc_pkg::HITS_W] == '0))
        else $error("hit reported on newline byte");

    // slots without a lane never report a hit
    a_unused_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[mkoc_pkg::HITS_LSB +: mkoc_pkg::HITS_W]
                       >> NUM_KEYWORDS) == '0))
        else $error("hit on unused keyword slot");

    // full output register with a stalled sink blocks the input
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result is stalled");

    // pad bits above the fields stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[mkoc_pkg::OUT_DATA_W-1 -: PAD_W] == '0))
        else $error("pad bits set in result");

endmodule
